### hdl/alslux_pkg.sv
// shared types, constants and decode functions for the lux calculation unit
`default_nettype none

package alslux_pkg;

   localparam int COUNT_W = 16;
   localparam int TOTAL_W = COUNT_W + 1;
   localparam int CODE_W = 3;
   localparam int LUX_W = 16;
   localparam int LIMIT_W = TOTAL_W + 10;
   localparam int COEF_W = 13;
   localparam int SUM_W = 29;
   localparam int RECIP_HALF_W = 17;
   localparam int RECIP_W = 2 * RECIP_HALF_W;
   localparam int RECIP_SHIFT = 35;
   localparam int PROD_W = SUM_W + RECIP_HALF_W;
   localparam int QUOT_W = SUM_W + 1;
   localparam int QUOT_LSB = RECIP_SHIFT - 1;
   localparam int WIDE_W = QUOT_LSB + QUOT_W;
   localparam int SHIFT_W = 5;

   // register indexes
   localparam logic CSR_GAIN_CODE = 1'b0;
   localparam logic CSR_INTEGRATION_CODE = 1'b1;

   // ratio thresholds in 1/1024 units
   localparam logic [9:0] RATIO_LOW = 10'd460;
   localparam logic [9:0] RATIO_MID = 10'd655;
   localparam logic [9:0] RATIO_HIGH = 10'd870;

   // segment weights, 13-bit fixed point with 10 fraction bits
   localparam logic [COEF_W-1:0] COEF_LOW_CH0 = 13'd1816;
   localparam logic [COEF_W-1:0] COEF_LOW_CH1 = 13'd1132;
   localparam logic [COEF_W-1:0] COEF_MID_CH0 = 13'd4381;
   localparam logic [COEF_W-1:0] COEF_MID_CH1 = 13'd2001;
   localparam logic [COEF_W-1:0] COEF_HIGH_CH0 = 13'd606;
   localparam logic [COEF_W-1:0] COEF_HIGH_CH1 = 13'd121;

   // ceil(2^35 / m) for the odd parts m of gain times integration factor / 5
   localparam logic [63:0] RECIP_3_FULL = ((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3;
   localparam logic [63:0] RECIP_5_FULL = ((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5;
   localparam logic [63:0] RECIP_7_FULL = ((64'd1 << RECIP_SHIFT) + 64'd6) / 64'd7;
   localparam logic [63:0] RECIP_9_FULL = ((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9;
   localparam logic [63:0] RECIP_15_FULL = ((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15;
   localparam logic [63:0] RECIP_21_FULL = ((64'd1 << RECIP_SHIFT) + 64'd20) / 64'd21;
   localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_3_FULL[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_5_FULL[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_7_FULL[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_9_FULL[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_15_FULL[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] RECIP_21 = RECIP_21_FULL[RECIP_W-1:0];

   // rounding point sits nine bits above the 1/1024 lux step
   localparam logic [SHIFT_W-1:0] ROUND_SHIFT = 5'd9;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_ZERO,
      STATUS_BAD_GAIN,
      STATUS_RANGE
   } status_type;

   typedef enum logic [1:0] {
      SEG_LOW,
      SEG_MID,
      SEG_HIGH
   } seg_type;

   // divisor 2 / (gain * itf / 5) split into odd reciprocal and power of two
   typedef struct packed {
      logic                 unity;
      logic [RECIP_W-1:0]   recip;
      logic [SHIFT_W-1:0]   shift;
   } div_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      div_type    div;
   } ctrl_type;

   function automatic logic gain_is_valid(input logic [CODE_W-1:0] gain);
      logic ok;
      unique case (gain)
         3'd4, 3'd5: ok = 1'b0;
         default:    ok = 1'b1;
      endcase
      return ok;
   endfunction

   function automatic div_type decode_divisor(input logic [CODE_W-1:0] gain,
                                              input logic [CODE_W-1:0] itime);
      logic [2:0] gexp;
      logic       gthree;
      logic [1:0] kexp;
      logic [2:0] kodd;
      logic [4:0] odd;
      div_type    d;
      unique case (gain)
         3'd0:    begin gexp = 3'd0; gthree = 1'b0; end
         3'd1:    begin gexp = 3'd1; gthree = 1'b0; end
         3'd2:    begin gexp = 3'd2; gthree = 1'b0; end
         3'd3:    begin gexp = 3'd3; gthree = 1'b0; end
         3'd6:    begin gexp = 3'd4; gthree = 1'b1; end
         3'd7:    begin gexp = 3'd5; gthree = 1'b1; end
         default: begin gexp = 3'd0; gthree = 1'b0; end
      endcase
      // itf / 5: 2, 1, 4, 8, 3, 5, 6, 7
      unique case (itime)
         3'd0:    begin kexp = 2'd1; kodd = 3'd1; end
         3'd1:    begin kexp = 2'd0; kodd = 3'd1; end
         3'd2:    begin kexp = 2'd2; kodd = 3'd1; end
         3'd3:    begin kexp = 2'd3; kodd = 3'd1; end
         3'd4:    begin kexp = 2'd0; kodd = 3'd3; end
         3'd5:    begin kexp = 2'd0; kodd = 3'd5; end
         3'd6:    begin kexp = 2'd1; kodd = 3'd3; end
         default: begin kexp = 2'd0; kodd = 3'd7; end
      endcase
      odd = gthree ? 5'(kodd) * 5'd3 : 5'(kodd);
      d.unity = 1'b0;
      unique case (odd)
         5'd3:    d.recip = RECIP_3;
         5'd5:    d.recip = RECIP_5;
         5'd7:    d.recip = RECIP_7;
         5'd9:    d.recip = RECIP_9;
         5'd15:   d.recip = RECIP_15;
         5'd21:   d.recip = RECIP_21;
         default: begin
            d.unity = 1'b1;
            d.recip = '0;
         end
      endcase
      d.shift = SHIFT_W'(gexp) + SHIFT_W'(kexp) + ROUND_SHIFT;
      return d;
   endfunction

endpackage

`default_nettype wire

### hdl/als_two_channel_lux_calc_unit.sv
// top level of the two-channel ambient light lux calculation unit
//
// usage
// - a transaction is one pair of channel counts (ch0 visible plus ir, ch1 ir),
//   accepted at a rising edge where start is high and busy is low
// - busy is always low: the six-stage pipeline takes a new pair every cycle
// - each transaction gives one result: rsp_valid is high for exactly one cycle
//   with rsp_lux_value and rsp_status, when the pair leaves the last stage
// - results leave in the order the pairs came in; the receiver cannot stall,
//   so nothing ever waits inside the pipeline
// - throughput is one transaction per cycle; the pipeline has three front
//   stages (channel total, ratio compare, weighted sum) and three back stages
//   (reciprocal partial products, their sum, shift and round)
// - gain_code (index 0) and integration_code (index 1) are written through the
//   csr port and are sampled when a pair enters the pipeline
// - synchronous reset clears both codes to zero and drops all in-flight
//   transactions; no result appears until a new pair is accepted
// - status: ok, both counts zero, invalid gain code, or ratio out of range;
//   lux is zero for any status other than ok and saturates at 65535
`default_nettype none

module als_two_channel_lux_calc_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [alslux_pkg::COUNT_W-1:0] req_ch0_count,
   input  wire logic [alslux_pkg::COUNT_W-1:0] req_ch1_count,
   // response channel
   output logic                                rsp_valid,
   output logic [alslux_pkg::LUX_W-1:0]        rsp_lux_value,
   output logic [1:0]                          rsp_status,
   // register write port
   input  wire logic                           csr_write,
   input  wire logic                           csr_index,
   input  wire logic [alslux_pkg::CODE_W-1:0]  csr_data
);
   import alslux_pkg::*;

   logic [CODE_W-1:0] gain_code_ff, gain_code_in;
   logic [CODE_W-1:0] integration_code_ff, integration_code_in;
   logic              accept;
   ctrl_type          seg_ctrl;
   logic [SUM_W-1:0]  seg_sum;
   status_type        scale_status;

   // the pipeline never holds back, so a start is always taken
   assign busy = 1'b0;
   assign accept = start && !busy;

   // configuration registers
   always_comb begin
      gain_code_in = gain_code_ff;
      integration_code_in = integration_code_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN_CODE:        gain_code_in = csr_data;
            CSR_INTEGRATION_CODE: integration_code_in = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_code_ff <= '0;
         integration_code_ff <= '0;
      end else begin
         gain_code_ff <= gain_code_in;
         integration_code_ff <= integration_code_in;
      end
   end

   // stages 1 to 3: sum of the channels, ratio segment, weighted sum
   alslux_seg u_seg (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept),
      .ch0              (req_ch0_count),
      .ch1              (req_ch1_count),
      .gain_code        (gain_code_ff),
      .integration_code (integration_code_ff),
      .ctrl_out         (seg_ctrl),
      .sum_out          (seg_sum)
   );

   // stages 4 to 6: divide by gain times integration factor, round, clamp
   alslux_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .ctrl_in    (seg_ctrl),
      .sum_in     (seg_sum),
      .out_valid  (rsp_valid),
      .out_lux    (rsp_lux_value),
      .out_status (scale_status)
   );

   assign rsp_status = scale_status;

endmodule

`default_nettype wire

### hdl/alslux_seg.sv
// front pipeline: channel total, ratio segment compare and weighted sum
`default_nettype none

module alslux_seg (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [alslux_pkg::COUNT_W-1:0] ch0,
   input  wire logic [alslux_pkg::COUNT_W-1:0] ch1,
   input  wire logic [alslux_pkg::CODE_W-1:0]  gain_code,
   input  wire logic [alslux_pkg::CODE_W-1:0]  integration_code,
   output alslux_pkg::ctrl_type               ctrl_out,
   output logic [alslux_pkg::SUM_W-1:0]        sum_out
);
   import alslux_pkg::*;

   // stage 1
   ctrl_type             s1_ctrl_ff, s1_ctrl_in;
   logic [COUNT_W-1:0]   s1_ch0_ff, s1_ch1_ff;
   logic [TOTAL_W-1:0]   s1_total_ff, s1_total_in;
   // stage 2
   ctrl_type             s2_ctrl_ff, s2_ctrl_in;
   logic [COUNT_W-1:0]   s2_ch0_ff, s2_ch1_ff;
   seg_type              s2_seg_ff, s2_seg_in;
   // stage 3
   ctrl_type             s3_ctrl_ff;
   logic [SUM_W-1:0]     s3_sum_ff, s3_sum_in;

   logic [LIMIT_W-1:0]   ch1_scaled;
   logic [LIMIT_W-1:0]   lim_low, lim_mid, lim_high;
   logic [SUM_W-1:0]     term0, term1;

   always_comb begin
      s1_total_in = TOTAL_W'(ch0) + TOTAL_W'(ch1);
      s1_ctrl_in.valid = in_valid;
      s1_ctrl_in.div = decode_divisor(gain_code, integration_code);
      priority if (s1_total_in == '0) begin
         s1_ctrl_in.status = STATUS_ZERO;
      end else if (!gain_is_valid(gain_code)) begin
         s1_ctrl_in.status = STATUS_BAD_GAIN;
      end else begin
         s1_ctrl_in.status = STATUS_OK;
      end
   end

   // floor(1024 ch1 / total) < n  <=>  1024 ch1 < n total
   always_comb begin
      ch1_scaled = {1'b0, s1_ch1_ff, 10'b0};
      lim_low = LIMIT_W'(s1_total_ff) * LIMIT_W'(RATIO_LOW);
      lim_mid = LIMIT_W'(s1_total_ff) * LIMIT_W'(RATIO_MID);
      lim_high = LIMIT_W'(s1_total_ff) * LIMIT_W'(RATIO_HIGH);
      s2_ctrl_in = s1_ctrl_ff;
      priority if (ch1_scaled < lim_low) begin
         s2_seg_in = SEG_LOW;
      end else if (ch1_scaled < lim_mid) begin
         s2_seg_in = SEG_MID;
      end else begin
         s2_seg_in = SEG_HIGH;
      end
      if (s1_ctrl_ff.status == STATUS_OK && !(ch1_scaled < lim_high)) begin
         s2_ctrl_in.status = STATUS_RANGE;
      end
   end

   always_comb begin
      unique case (s2_seg_ff)
         SEG_LOW: begin
            term0 = SUM_W'(s2_ch0_ff) * SUM_W'(COEF_LOW_CH0);
            term1 = SUM_W'(s2_ch1_ff) * SUM_W'(COEF_LOW_CH1);
         end
         SEG_MID: begin
            term0 = SUM_W'(s2_ch0_ff) * SUM_W'(COEF_MID_CH0);
            term1 = SUM_W'(s2_ch1_ff) * SUM_W'(COEF_MID_CH1);
         end
         default: begin
            term0 = SUM_W'(s2_ch0_ff) * SUM_W'(COEF_HIGH_CH0);
            term1 = SUM_W'(s2_ch1_ff) * SUM_W'(COEF_HIGH_CH1);
         end
      endcase
      if (s2_seg_ff == SEG_MID) begin
         s3_sum_in = (term0 > term1) ? term0 - term1 : '0;
      end else begin
         s3_sum_in = term0 + term1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= s1_ctrl_in;
         s2_ctrl_ff <= s2_ctrl_in;
         s3_ctrl_ff <= s2_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ch0_ff <= ch0;
      s1_ch1_ff <= ch1;
      s1_total_ff <= s1_total_in;
      s2_ch0_ff <= s1_ch0_ff;
      s2_ch1_ff <= s1_ch1_ff;
      s2_seg_ff <= s2_seg_in;
      s3_sum_ff <= s3_sum_in;
   end

   assign ctrl_out = s3_ctrl_ff;
   assign sum_out = s3_sum_ff;

endmodule

`default_nettype wire

### hdl/alslux_scale.sv
// back pipeline: reciprocal multiply, power-of-two shift, rounding and saturation
`default_nettype none

module alslux_scale (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire alslux_pkg::ctrl_type        ctrl_in,
   input  wire logic [alslux_pkg::SUM_W-1:0] sum_in,
   output logic                             out_valid,
   output logic [alslux_pkg::LUX_W-1:0]      out_lux,
   output alslux_pkg::status_type           out_status
);
   import alslux_pkg::*;

   // stage 4: two partial products of sum times reciprocal
   ctrl_type            s4_ctrl_ff;
   logic [SUM_W-1:0]    s4_sum_ff;
   logic [PROD_W-1:0]   s4_lo_ff, s4_lo_in;
   logic [PROD_W-1:0]   s4_hi_ff, s4_hi_in;
   // stage 5: quotient floor(2 sum / m)
   ctrl_type            s5_ctrl_ff;
   logic [QUOT_W-1:0]   s5_quot_ff, s5_quot_in;
   logic [WIDE_W-1:0]   wide;
   // stage 6: result registers
   logic                out_valid_ff;
   logic [LUX_W-1:0]    out_lux_ff, out_lux_in;
   status_type          out_status_ff;
   logic [QUOT_W-1:0]   shifted, rounded;

   always_comb begin
      s4_lo_in = PROD_W'(sum_in) * PROD_W'(ctrl_in.div.recip[RECIP_HALF_W-1:0]);
      s4_hi_in = PROD_W'(sum_in) * PROD_W'(ctrl_in.div.recip[RECIP_W-1:RECIP_HALF_W]);
   end

   always_comb begin
      wide = (WIDE_W'(s4_hi_ff) << RECIP_HALF_W) + WIDE_W'(s4_lo_ff);
      if (s4_ctrl_ff.div.unity) begin
         s5_quot_in = {s4_sum_ff, 1'b0};
      end else begin
         s5_quot_in = wide[WIDE_W-1:QUOT_LSB];
      end
   end

   // round half up at bit 9 of the scaled value, then clamp to 16 bits
   always_comb begin
      shifted = s5_quot_ff >> s5_ctrl_ff.div.shift;
      rounded = {1'b0, shifted[QUOT_W-1:1]} + QUOT_W'(shifted[0]);
      if (s5_ctrl_ff.status != STATUS_OK) begin
         out_lux_in = '0;
      end else if (rounded[QUOT_W-1:LUX_W] != '0) begin
         out_lux_in = '1;
      end else begin
         out_lux_in = rounded[LUX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctrl_ff <= '0;
         s5_ctrl_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s4_ctrl_ff <= ctrl_in;
         s5_ctrl_ff <= s4_ctrl_ff;
         out_valid_ff <= s5_ctrl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      s4_sum_ff <= sum_in;
      s4_lo_ff <= s4_lo_in;
      s4_hi_ff <= s4_hi_in;
      s5_quot_ff <= s5_quot_in;
      out_lux_ff <= out_lux_in;
      out_status_ff <= s5_ctrl_ff.status;
   end

   assign out_valid = out_valid_ff;
   assign out_lux = out_lux_ff;
   assign out_status = out_status_ff;

endmodule

`default_nettype wire

### verif/lux_result_checker.sv
// checker that predicts lux results from accepted count pairs and compares them
`timescale 1ns / 1ps

module lux_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [alslux_pkg::COUNT_W-1:0] req_ch0_count,
   input  logic [alslux_pkg::COUNT_W-1:0] req_ch1_count,
   input  logic                           rsp_valid,
   input  logic [alslux_pkg::LUX_W-1:0]   rsp_lux_value,
   input  logic [1:0]                     rsp_status,
   input  logic                           csr_write,
   input  logic                           csr_index,
   input  logic [alslux_pkg::CODE_W-1:0]  csr_data,
   output int                             fail_count,
   output int                             lux_pending
);
   import alslux_pkg::*;

   typedef struct packed {
      logic [COUNT_W-1:0] ch0;
      logic [COUNT_W-1:0] ch1;
      logic [LUX_W-1:0]   lux;
      status_type         status;
   } lux_result_type;

   // multipliers indexed by register code, zero marks an invalid gain
   localparam logic [7:0][7:0] GAIN_SCALE =
      {8'd96, 8'd48, 8'd0, 8'd0, 8'd8, 8'd4, 8'd2, 8'd1};
   // integration time in 10 ms units
   localparam logic [7:0][5:0] ITIME_FACTOR =
      {6'd35, 6'd30, 6'd25, 6'd15, 6'd40, 6'd20, 6'd5, 6'd10};

   localparam longint unsigned MID_FROM   = 460;
   localparam longint unsigned HIGH_FROM  = 655;
   localparam longint unsigned RANGE_FROM = 870;
   localparam longint unsigned W_LOW_CH0  = 1816;
   localparam longint unsigned W_LOW_CH1  = 1132;
   localparam longint unsigned W_MID_CH0  = 4381;
   localparam longint unsigned W_MID_CH1  = 2001;
   localparam longint unsigned W_HIGH_CH0 = 606;
   localparam longint unsigned W_HIGH_CH1 = 121;
   localparam longint unsigned LUX_MAX    = 65535;

   lux_result_type    lux_expected [$];
   logic [CODE_W-1:0] gain_code_q  = '0;
   logic [CODE_W-1:0] itime_code_q = '0;
   int                mismatch_total = 0;
   int                pending_total  = 0;

   assign fail_count  = mismatch_total;
   assign lux_pending = pending_total;

   function automatic lux_result_type predict_lux(input logic [COUNT_W-1:0] ch0,
                                                  input logic [COUNT_W-1:0] ch1,
                                                  input logic [CODE_W-1:0]  gcode,
                                                  input logic [CODE_W-1:0]  icode);
      lux_result_type  res;
      longint unsigned c0;
      longint unsigned c1;
      longint unsigned ratio;
      longint unsigned weighted;
      longint unsigned scaled;
      longint unsigned lux;
      res.ch0    = ch0;
      res.ch1    = ch1;
      res.lux    = '0;
      res.status = STATUS_OK;
      c0 = ch0;
      c1 = ch1;
      // zero counts take precedence over a bad gain
      if (c0 == 0 && c1 == 0) begin
         res.status = STATUS_ZERO;
         return res;
      end
      if (GAIN_SCALE[gcode] == 0) begin
         res.status = STATUS_BAD_GAIN;
         return res;
      end
      ratio = (c1 * 1024) / (c0 + c1);
      if (ratio >= RANGE_FROM) begin
         res.status = STATUS_RANGE;
         return res;
      end
      if (ratio < MID_FROM)
         weighted = W_LOW_CH0 * c0 + W_LOW_CH1 * c1;
      else if (ratio < HIGH_FROM)
         weighted = (W_MID_CH0 * c0 > W_MID_CH1 * c1) ? W_MID_CH0 * c0 - W_MID_CH1 * c1 : 0;
      else
         weighted = W_HIGH_CH0 * c0 + W_HIGH_CH1 * c1;
      scaled = (weighted * 10) / (longint'(GAIN_SCALE[gcode]) * longint'(ITIME_FACTOR[icode]));
      lux = scaled / 1024;
      if (scaled % 1024 >= 512)
         lux = lux + 1;
      res.lux = (lux > LUX_MAX) ? LUX_MAX[LUX_W-1:0] : lux[LUX_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_total = mismatch_total + 1;
   endtask

   always @(posedge clock) begin : watch
      lux_result_type want;
      if (reset) begin
         lux_expected.delete();
         gain_code_q  = '0;
         itime_code_q = '0;
      end else begin
         if (rsp_valid) begin
            if (lux_expected.size() == 0) begin
               report_mismatch($sformatf("result lux %0d status %0d with no transaction waiting",
                                         rsp_lux_value, rsp_status));
            end else begin
               want = lux_expected.pop_front();
               if (rsp_lux_value !== want.lux)
                  report_mismatch($sformatf("ch0 %0d ch1 %0d: lux_value %0d, expected %0d",
                                            want.ch0, want.ch1, rsp_lux_value, want.lux));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("ch0 %0d ch1 %0d: status %0d, expected %0d",
                                            want.ch0, want.ch1, rsp_status, want.status));
            end
         end
         // the pair sees the codes as they were before a write on the same edge
         if (start && !busy)
            lux_expected.push_back(predict_lux(req_ch0_count, req_ch1_count,
                                               gain_code_q, itime_code_q));
         if (csr_write) begin
            if (csr_index == CSR_GAIN_CODE)
               gain_code_q = csr_data;
            else
               itime_code_q = csr_data;
         end
      end
      pending_total = lux_expected.size();
   end

endmodule

### verif/tb_top.sv
// testbench top for the lux calculation unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
   import alslux_pkg::*;

   // run limits
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;     // pipeline is six deep, leave some margin
   localparam int PHASE_PAIRS  = 50;

   // register encodings used by the directed part
   localparam logic [CODE_W-1:0] GAIN_1X     = 3'd0;
   localparam logic [CODE_W-1:0] GAIN_BAD_LO = 3'd4;
   localparam logic [CODE_W-1:0] GAIN_BAD_HI = 3'd5;
   localparam logic [CODE_W-1:0] GAIN_48X    = 3'd6;
   localparam logic [CODE_W-1:0] GAIN_96X    = 3'd7;
   localparam logic [CODE_W-1:0] ITIME_100MS = 3'd0;
   localparam logic [CODE_W-1:0] ITIME_50MS  = 3'd1;
   localparam logic [CODE_W-1:0] ITIME_400MS = 3'd3;
   localparam logic [CODE_W-1:0] ITIME_350MS = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [COUNT_W-1:0] req_ch0_count = '0;
   logic [COUNT_W-1:0] req_ch1_count = '0;
   logic               rsp_valid;
   logic [LUX_W-1:0]   rsp_lux_value;
   logic [1:0]         rsp_status;
   logic               csr_write = 1'b0;
   logic               csr_index = CSR_GAIN_CODE;
   logic [CODE_W-1:0]  csr_data  = '0;

   int fail_count;
   int lux_pending;
   int cycle_count = 0;
   int idle_pct    = 0;   // chance in percent that the sender skips a cycle

   always #5 clock = ~clock;

   als_two_channel_lux_calc_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_ch0_count (req_ch0_count),
      .req_ch1_count (req_ch1_count),
      .rsp_valid     (rsp_valid),
      .rsp_lux_value (rsp_lux_value),
      .rsp_status    (rsp_status),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // watches both channels and the register port, predicts and compares
   lux_result_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_ch0_count (req_ch0_count),
      .req_ch1_count (req_ch1_count),
      .rsp_valid     (rsp_valid),
      .rsp_lux_value (rsp_lux_value),
      .rsp_status    (rsp_status),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .lux_pending   (lux_pending)
   );

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // one transaction: optional idle cycles, then hold start until busy is low;
   // called and returning at a falling edge, so start is assigned once per step
   task automatic send_pair(input logic [COUNT_W-1:0] ch0, input logic [COUNT_W-1:0] ch1);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_ch0_count <= ch0;
      req_ch1_count <= ch1;
      // busy only moves at rising edges, so its value here holds at the next one
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // both registers, one per cycle, write enable held across the pair
   task automatic write_codes(input logic [CODE_W-1:0] gain, input logic [CODE_W-1:0] itime);
      csr_write <= 1'b1;
      csr_index <= CSR_GAIN_CODE;
      csr_data  <= gain;
      @(negedge clock);
      csr_index <= CSR_INTEGRATION_CODE;
      csr_data  <= itime;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // stop sending and let the pipeline empty before touching the registers
   task automatic settle();
      start <= 1'b0;
      while (lux_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // count pairs: four in ten aimed around the segment thresholds, plus full range,
   // tiny values, bright scenes and single dark channels
   task automatic random_pair(output logic [COUNT_W-1:0] ch0, output logic [COUNT_W-1:0] ch1);
      int unsigned mode;
      int unsigned total;
      int unsigned ratio_pick;
      int unsigned ir;
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
         // ratio in 1/1024 units near the three thresholds
         total      = $urandom_range(1, 65535);
         ratio_pick = $urandom_range(440, 890);
         ir         = (total * ratio_pick + 1023) / 1024;
         if (ir > total)
            ir = total;
         ch1 = ir[COUNT_W-1:0];
         ch0 = 16'(total - ir);
      end else if (mode < 7) begin
         ch0 = 16'($urandom());
         ch1 = 16'($urandom());
      end else if (mode == 7) begin
         ch0 = 16'($urandom_range(0, 15));
         ch1 = 16'($urandom_range(0, 15));
      end else if (mode == 8) begin
         ch0 = 16'($urandom_range(32768, 65535));
         ch1 = 16'($urandom_range(0, 32767));
      end else begin
         ch0 = ($urandom_range(0, 1) == 0) ? 16'($urandom()) : '0;
         ch1 = (ch0 == 0) ? 16'($urandom()) : '0;
      end
   endtask

   initial begin : stimulus
      int                 regime;
      int                 phase;
      int                 n;
      logic [COUNT_W-1:0] a;
      logic [COUNT_W-1:0] b;
      logic [CODE_W-1:0]  g;
      logic [CODE_W-1:0]  t;

      // reset held high from the start, released at a falling edge
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, first at the reset codes (1x gain, 100 ms)
      idle_pct = 14;
      send_pair(16'd0, 16'd0);           // both channels dark
      send_pair(16'd65535, 16'd0);       // brightest visible, lux saturates
      send_pair(16'd0, 16'd65535);       // pure ir, ratio far out of range
      send_pair(16'd65535, 16'd65535);   // both full, middle segment
      send_pair(16'd1, 16'd0);
      send_pair(16'd0, 16'd1);
      send_pair(16'd565, 16'd459);       // last ratio of the low segment
      send_pair(16'd564, 16'd460);       // first ratio of the middle segment
      send_pair(16'd370, 16'd654);       // last ratio of the middle segment
      send_pair(16'd369, 16'd655);       // first ratio of the high segment
      send_pair(16'd155, 16'd869);       // last ratio of the high segment
      send_pair(16'd154, 16'd870);       // ratio just out of range
      send_pair(16'd1, 16'd1);
      settle();

      // invalid gain codes; dark pair must still report zero counts
      write_codes(GAIN_BAD_LO, ITIME_100MS);
      send_pair(16'd0, 16'd0);
      send_pair(16'd1000, 16'd200);
      settle();
      write_codes(GAIN_BAD_HI, ITIME_350MS);
      send_pair(16'd1000, 16'd200);
      send_pair(16'd65535, 16'd65535);
      settle();

      // smallest divisor (gain 1x, 50 ms): saturation is easy to reach
      write_codes(GAIN_1X, ITIME_50MS);
      send_pair(16'd65535, 16'd65535);
      send_pair(16'd40000, 16'd0);
      send_pair(16'd300, 16'd100);
      settle();

      // largest divisor (gain 96x, 400 ms): small counts round to zero
      write_codes(GAIN_96X, ITIME_400MS);
      send_pair(16'd1, 16'd0);
      send_pair(16'd65535, 16'd0);
      send_pair(16'd32768, 16'd32767);
      settle();
      write_codes(GAIN_48X, ITIME_350MS);
      send_pair(16'd512, 16'd512);
      settle();

      // random part: sender idles 14 percent, then 59 percent, then never
      for (regime = 0; regime < 3; regime++) begin
         idle_pct = (regime == 0) ? 14 : (regime == 1) ? 59 : 0;
         for (phase = 0; phase < 3; phase++) begin
            if (regime == 0 && phase == 0) begin
               g = GAIN_1X;
               t = ITIME_50MS;
            end else if (regime == 0 && phase == 1) begin
               g = GAIN_96X;
               t = ITIME_400MS;
            end else begin
               g = 3'($urandom_range(0, 7));
               t = 3'($urandom_range(0, 7));
               // invalid gains only now and then, they flatten every result
               if ($urandom_range(0, 3) != 0)
                  while (!gain_is_valid(g)) g = 3'($urandom_range(0, 7));
            end
            write_codes(g, t);
            for (n = 0; n < PHASE_PAIRS; n++) begin
               random_pair(a, b);
               send_pair(a, b);
            end
            settle();
         end
      end

      if (fail_count == 0 && lux_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
